>>> src/hse_pkg.sv
// Shared types and constants for the heap sort engine.
package hse_pkg;

  // Width of one data word
  localparam int unsigned ValueW = 32;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_BLD_RD,
    S_BLD_LD,
    S_CHK,
    S_LC,
    S_RC,
    S_CMP,
    S_EXT_RA,
    S_EXT_RB,
    S_EXT_WR,
    S_EM_RD,
    S_EM_LD
  } hse_state_e;

  // Output register load request from the sequencer
  typedef struct packed {
    logic ld;
    logic last;
    logic ovf;
  } hse_emit_t;

endpackage

>>> src/heap_sort_engine.sv
// Heap sort engine top level: store, sequencer and output register.
//
//   channel   dir  tdata            tlast      tuser
//   s_axis    in   value[31:0]      last_item  -
//   m_axis    out  sorted_value     last_out   overflowed
//
// Words are stored one per cycle while tready is high. The word with tlast
// starts the sort; tready stays low until the final sorted word is loaded.
// Each sift level steps through S_CHK, S_LC, S_RC (when a right child exists)
// and S_CMP on the single store port. Each output word is read in S_EM_RD
// and loaded in S_EM_LD; a stall on m_axis holds the sequencer. Reset clears
// the count and overflow flag; no store clearing.
module heap_sort_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [hse_pkg::ValueW-1:0]    s_axis_tdata_i,  // [31:0] value
  input  logic                          s_axis_tlast_i,  // last_item
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [hse_pkg::ValueW-1:0]    m_axis_tdata_o,  // [31:0] sorted_value
  output logic                          m_axis_tlast_o,  // last_out
  output logic                          m_axis_tuser_o   // [0] overflowed
);
  import hse_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [ValueW-1:0] wdata, rdata;
  hse_emit_t         emit;
  logic              out_free;

  logic              out_vld_q;
  logic [ValueW-1:0] out_data_q;
  logic              out_last_q;
  logic              out_ovf_q;

  hse_store #(.DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  hse_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_value_i (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .out_free_i (out_free),
    .emit_o     (emit),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  assign out_free = !out_vld_q || m_axis_tready_i;

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit.ld) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk_i) begin
    if (emit.ld) begin
      out_data_q <= rdata;
      out_last_q <= emit.last;
      out_ovf_q  <= emit.ovf;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

endmodule

>>> src/hse_store.sv
// Heap store: one write port, one read port with registered read data.
module hse_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(DEPTH)-1:0]            waddr_i,
  input  logic [hse_pkg::ValueW-1:0]          wdata_i,
  input  logic [$clog2(DEPTH)-1:0]            raddr_i,
  output logic [hse_pkg::ValueW-1:0]          rdata_o
);
  import hse_pkg::*;

  logic [ValueW-1:0] mem [DEPTH];
  logic [ValueW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/hse_ctrl.sv
// Sort sequencer: loads words, builds the max-heap, extracts and emits in order.
module hse_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hse_pkg::ValueW-1:0]          in_value_i,
  input  logic                                in_last_i,
  input  logic                                out_free_i,
  output hse_pkg::hse_emit_t                  emit_o,
  output logic                                we_o,
  output logic [$clog2(DEPTH)-1:0]            waddr_o,
  output logic [hse_pkg::ValueW-1:0]          wdata_o,
  output logic [$clog2(DEPTH)-1:0]            raddr_o,
  input  logic [hse_pkg::ValueW-1:0]          rdata_i
);
  import hse_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hse_state_e        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              build_q, build_d;
  logic [AW-1:0]     node_q, node_d;
  logic [AW-1:0]     last_q, last_d;
  logic [AW-1:0]     nm1_q, nm1_d;
  logic [AW-1:0]     k_q, k_d;
  logic [AW-1:0]     pick_q, pick_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [ValueW-1:0] lcv_q, lcv_d;
  logic [ValueW-1:0] pickv_q, pickv_d;

  // child indexes, wide enough to exceed the heap end
  logic [AW+1:0]     lc_w, rc_w, last_ext;
  logic              has_lc, has_rc;

  // shared signed comparator
  logic [ValueW-1:0] cmp_a, cmp_b;
  logic              cmp_gt;

  logic              full;
  logic [CW-1:0]     n_new, nm1_w;

  assign lc_w     = {1'b0, node_q, 1'b1};
  assign rc_w     = lc_w + (AW+2)'(1);
  assign last_ext = {2'b00, last_q};
  assign has_lc   = (lc_w <= last_ext);
  assign has_rc   = (rc_w <= last_ext);

  assign cmp_a  = (state_q == S_RC) ? rdata_i : pickv_q;
  assign cmp_b  = (state_q == S_RC) ? lcv_q   : val_q;
  assign cmp_gt = ($signed(cmp_a) > $signed(cmp_b));

  assign full  = (cnt_q >= CW'(DEPTH));
  assign n_new = full ? cnt_q : cnt_q + CW'(1);
  assign nm1_w = n_new - CW'(1);

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      build_q <= build_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    last_q  <= last_d;
    nm1_q   <= nm1_d;
    k_q     <= k_d;
    pick_q  <= pick_d;
    val_q   <= val_d;
    lcv_q   <= lcv_d;
    pickv_q <= pickv_d;
  end

  // next state and outputs
  always_comb begin
    logic done;
    done       = 1'b0;
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    build_d    = build_q;
    node_d     = node_q;
    last_d     = last_q;
    nm1_d      = nm1_q;
    k_d        = k_q;
    pick_d     = pick_q;
    val_d      = val_q;
    lcv_d      = lcv_q;
    pickv_d    = pickv_q;
    in_ready_o = 1'b0;
    emit_o     = '0;
    we_o       = 1'b0;
    waddr_o    = node_q;
    wdata_o    = val_q;
    raddr_o    = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!full) begin
            we_o    = 1'b1;
            waddr_o = cnt_q[AW-1:0];
            wdata_o = in_value_i;
            cnt_d   = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            nm1_d   = nm1_w[AW-1:0];
            last_d  = nm1_w[AW-1:0];
            build_d = 1'b1;
            if (n_new < CW'(2)) begin
              k_d     = '0;
              state_d = S_EM_RD;
            end else begin
              k_d     = nm1_w[AW-1:0] >> 1;
              state_d = S_BLD_RD;
            end
          end
        end
      end
      // build: fetch the next inner node to sift
      S_BLD_RD: begin
        raddr_o = k_q;
        node_d  = k_q;
        state_d = S_BLD_LD;
      end
      S_BLD_LD: begin
        val_d   = rdata_i;
        state_d = S_CHK;
      end
      // sift: look for the left child
      S_CHK: begin
        if (has_lc) begin
          raddr_o = lc_w[AW-1:0];
          state_d = S_LC;
        end else begin
          we_o = 1'b1;
          done = 1'b1;
        end
      end
      S_LC: begin
        lcv_d   = rdata_i;
        pickv_d = rdata_i;
        pick_d  = lc_w[AW-1:0];
        if (has_rc) begin
          raddr_o = rc_w[AW-1:0];
          state_d = S_RC;
        end else begin
          state_d = S_CMP;
        end
      end
      // right child larger than left
      S_RC: begin
        if (cmp_gt) begin
          pickv_d = rdata_i;
          pick_d  = rc_w[AW-1:0];
        end
        state_d = S_CMP;
      end
      // larger child moves up, or the sifted word settles here
      S_CMP: begin
        we_o = 1'b1;
        if (cmp_gt) begin
          wdata_o = pickv_q;
          node_d  = pick_q;
          state_d = S_CHK;
        end else begin
          done = 1'b1;
        end
      end
      // extract: swap root with heap end, shrink, re-sift from root
      S_EXT_RA: begin
        raddr_o = last_q;
        state_d = S_EXT_RB;
      end
      S_EXT_RB: begin
        val_d   = rdata_i;
        raddr_o = '0;
        state_d = S_EXT_WR;
      end
      S_EXT_WR: begin
        we_o    = 1'b1;
        waddr_o = last_q;
        wdata_o = rdata_i;
        last_d  = last_q - AW'(1);
        node_d  = '0;
        state_d = S_CHK;
      end
      // emit in ascending order
      S_EM_RD: begin
        if (out_free_i) begin
          raddr_o = k_q;
          state_d = S_EM_LD;
        end
      end
      S_EM_LD: begin
        emit_o.ld   = 1'b1;
        emit_o.last = (k_q == nm1_q);
        emit_o.ovf  = ovf_q;
        if (k_q == nm1_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + AW'(1);
          state_d = S_EM_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // end of one sift pass
    if (done) begin
      if (build_q) begin
        if (k_q == '0) begin
          build_d = 1'b0;
          state_d = S_EXT_RA;
        end else begin
          k_d     = k_q - AW'(1);
          state_d = S_BLD_RD;
        end
      end else if (last_q == '0) begin
        k_d     = '0;
        state_d = S_EM_RD;
      end else begin
        state_d = S_EXT_RA;
      end
    end
  end

endmodule

>>> src/hse_checker.sv
// Port-level checks for the heap sort engine, bound to the top level.
module hse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          s_axis_tlast_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [hse_pkg::ValueW-1:0]    m_axis_tdata_o,
  input logic                          m_axis_tlast_o,
  input logic                          m_axis_tuser_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // the final word of a set closes the input until sorting is done
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input open right after a final word");

  // only the final word of a run can be pending while input is open
  a_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tlast_o)
    else $error("mid-run word pending while input open");

  // a run continues after a non-final word
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> !s_axis_tready_o)
    else $error("input open in the middle of a run");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> tb/tb.sv
// Self-checking testbench for heap_sort_engine: stream stimulus, heap sort predictor, checks.
module tb;
  import hse_pkg::*;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned DIR_N     = 24;
  localparam int unsigned RAND_N    = 360;
  localparam int unsigned IDLE_PCT  = 27;
  localparam int unsigned HOLD_CYC  = 400;
  localparam int unsigned DRAIN_CYC = 100;
  localparam int unsigned MAX_SHOWN = 10;

  // One sorted output word
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
    logic              ovf;
  } sorted_word_t;

  // Directed row: input word plus, for single-word sets, the typed-in result
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
    logic              typed;
    logic [ValueW-1:0] want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_tvalid;
  logic [ValueW-1:0] s_tdata;
  logic              s_tlast;
  logic              m_tready;
  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [ValueW-1:0] m_axis_tdata_o;
  logic              m_axis_tlast_o;
  logic              m_axis_tuser_o;

  heap_sort_engine #(.DEPTH(DEPTH)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),       // [31:0] value
    .s_axis_tlast_i  (s_tlast),       // last_item
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o), // [31:0] sorted_value
    .m_axis_tlast_o  (m_axis_tlast_o), // last_out
    .m_axis_tuser_o  (m_axis_tuser_o)  // [0] overflowed
  );

  // Directed stimulus: extremes, equal values, mixed signs, ordered runs
  dir_row_t dir_tab [0:DIR_N-1] = '{
    '{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff},
    '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b1, 1'b0, 32'h0},
    '{32'hffff_fffd, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
    '{32'hffff_ffff, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0028, 1'b0, 1'b0, 32'h0},
    '{32'h0000_001e, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0014, 1'b0, 1'b0, 32'h0},
    '{32'h0000_000a, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'hffff_fff6, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},
    '{32'haaaa_aaaa, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b1, 1'b0, 32'h0}
  };

  // Predictor state: the current set and its overflow flag
  logic [ValueW-1:0] set_mem [0:DEPTH-1];
  int unsigned       set_cnt;
  bit                set_drop;

  sorted_word_t sorted_q [$];   // expected sorted words, oldest first
  sorted_word_t fresh_q  [$];   // words produced by the latest input word

  int unsigned err_cnt;
  int unsigned rx_cnt;
  bit          steady;          // no idling on either side while set

  // Sift a node down within the heap ending at last_idx
  function automatic void sift_down(int unsigned node, int unsigned last_idx);
    int unsigned       lc;
    int unsigned       pick;
    logic [ValueW-1:0] t;
    bit                done;
    done = 1'b0;
    while (!done && (2 * node + 1 <= last_idx)) begin
      lc   = 2 * node + 1;
      pick = lc;
      if (lc + 1 <= last_idx && $signed(set_mem[lc+1]) > $signed(set_mem[lc])) pick = lc + 1;
      if (!($signed(set_mem[pick]) > $signed(set_mem[node]))) begin
        done = 1'b1;
      end else begin
        t             = set_mem[pick];
        set_mem[pick] = set_mem[node];
        set_mem[node] = t;
        node          = pick;
      end
    end
  endfunction

  // Build the max-heap, then move the root to the end repeatedly
  function automatic void heap_sort_set(int unsigned n);
    int unsigned       last_idx;
    int unsigned       k;
    logic [ValueW-1:0] t;
    if (n >= 2) begin
      last_idx = n - 1;
      k        = last_idx / 2 + 1;
      while (k > 0) begin
        k--;
        sift_down(k, last_idx);
      end
      while (last_idx >= 1) begin
        t                 = set_mem[last_idx];
        set_mem[last_idx] = set_mem[0];
        set_mem[0]        = t;
        last_idx--;
        sift_down(0, last_idx);
      end
    end
  endfunction

  // Take one accepted input word; on last, leave the sorted set in fresh_q
  function automatic void absorb_word(logic [ValueW-1:0] v, logic lst);
    sorted_word_t w;
    fresh_q.delete();
    if (set_cnt < DEPTH) begin
      set_mem[set_cnt] = v;
      set_cnt++;
    end else begin
      set_drop = 1'b1;
    end
    if (lst) begin
      heap_sort_set(set_cnt);
      for (int unsigned k = 0; k < set_cnt; k++) begin
        w.value = set_mem[k];
        w.last  = (k + 1 == set_cnt);
        w.ovf   = set_drop;
        fresh_q.push_back(w);
      end
      set_cnt  = 0;
      set_drop = 1'b0;
    end
  endfunction

  // Mix of full-range, clustered (duplicates) and extreme values
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom;
    if (r < 80) return $urandom_range(8) - 4;
    case ($urandom_range(4))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Offer one word on s_axis; entered and left at a falling edge
  task automatic push_word(logic [ValueW-1:0] v, logic lst, logic typed,
                           logic [ValueW-1:0] want);
    sorted_word_t w;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_word(v, lst);
    if (typed) begin
      w.value = want;
      w.last  = 1'b1;
      w.ovf   = 1'b0;
      sorted_q.push_back(w);
    end else begin
      foreach (fresh_q[i]) sorted_q.push_back(fresh_q[i]);
    end
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic note_error(string what, sorted_word_t want, sorted_word_t got);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN)
      $display("%0t %s: want value %h last %b ovf %b, got value %h last %b ovf %b",
               $realtime, what, want.value, want.last, want.ovf,
               got.value, got.last, got.ovf);
  endtask

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Output checker: compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin : chk_blk
    sorted_word_t got;
    sorted_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      got.value = m_axis_tdata_o;
      got.last  = m_axis_tlast_o;
      got.ovf   = m_axis_tuser_o;
      rx_cnt++;
      if (sorted_q.size() == 0) begin
        note_error("unexpected word", '0, got);
      end else begin
        want = sorted_q.pop_front();
        if (got !== want) note_error("mismatch", want, got);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once results are flowing
  initial begin : rx_proc
    int unsigned hold_left;
    bit          hold_done;
    m_tready  = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && rx_cnt >= 40) begin
        hold_left = HOLD_CYC;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Run time limit
  initial begin
    #3_000_000;
    $display("tb: errors");
    $finish;
  end

  // Stimulus
  initial begin : stim_proc
    int unsigned sent;
    int unsigned set_idx;
    int unsigned set_len;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    steady   = 1'b0;
    set_cnt  = 0;
    set_drop = 1'b0;
    err_cnt  = 0;
    rx_cnt   = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part
    for (int i = 0; i < DIR_N; i++)
      push_word(dir_tab[i].value, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);

    // Random sets: mostly small, one exactly full, one past the store depth
    sent    = 0;
    set_idx = 0;
    while (sent < RAND_N) begin
      if (set_idx == 0 || set_idx == 7) drain_results();
      steady = (set_idx >= 12 && set_idx < 20);
      if (set_idx == 4)      set_len = DEPTH;
      else if (set_idx == 9) set_len = DEPTH + 2;
      else                   set_len = $urandom_range(10, 1);
      for (int unsigned i = 0; i < set_len; i++)
        push_word(pick_value(), i + 1 == set_len, 1'b0, '0);
      sent += set_len;
      set_idx++;
    end
    steady = 1'b0;

    // Let every expected word out, then watch for strays
    drain_results();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/hse_pkg.sv
src/hse_store.sv
src/hse_ctrl.sv
src/heap_sort_engine.sv
src/hse_checker.sv
tb/tb.sv
